@@ rtl/bfcs_pkg.sv @@
// Package for the threshold city selector: widths, codes, edge and
// relaxation types, and the sequencer state type. Depends on nothing.
`default_nettype none
package bfcs_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 2048;

  localparam int NODE_ID_W = 6;
  localparam int WEIGHT_W  = 16;
  localparam int DIST_W    = 23;
  localparam int THR_W     = 22;
  localparam int NCOUNT_W  = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIST_W-1:0] DIST_INF  = 23'h400000;
  localparam logic [DIST_W-1:0] DIST_ZERO = 23'h000000;
  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b1;

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_RUN      = 1'b1;

  typedef struct packed {
    logic [NODE_ID_W-1:0] node_a;
    logic [NODE_ID_W-1:0] node_b;
    logic [WEIGHT_W-1:0]  weight;
  } edge_t;

  typedef struct packed {
    logic [DIST_W-1:0] value;
    logic              lower;
  } relax_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_EDGE_RD,
    ST_DIST_RD,
    ST_RELAX_B,
    ST_RELAX_A,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_PICK,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/bfcs_relax_unit.sv @@
// Shared relaxation unit: saturating distance plus weight and a compare
// against the current distance. Depends on bfcs_pkg.
`default_nettype none
module bfcs_relax_unit (
  input  wire logic [bfcs_pkg::DIST_W-1:0]   base_dist,
  input  wire logic [bfcs_pkg::WEIGHT_W-1:0] weight,
  input  wire logic [bfcs_pkg::DIST_W-1:0]   cur,
  output bfcs_pkg::relax_t                   result
);

  logic [bfcs_pkg::DIST_W:0]   sum;
  logic [bfcs_pkg::DIST_W-1:0] cand;

  always_comb begin
    sum = {1'b0, base_dist} + (bfcs_pkg::DIST_W + 1)'(weight);
    if (base_dist[bfcs_pkg::DIST_W-1] ||
        (sum >= (bfcs_pkg::DIST_W + 1)'(bfcs_pkg::DIST_INF))) begin
      cand = bfcs_pkg::DIST_INF;
    end else begin
      cand = sum[bfcs_pkg::DIST_W-1:0];
    end
    result.value = cand;
    result.lower = (cand < cur);
  end

endmodule
`default_nettype wire

@@ rtl/bfcs_edge_store.sv @@
// Edge store memory: one write port for loads, one registered read port
// for the relaxation walk. Depends on bfcs_pkg.
`default_nettype none
module bfcs_edge_store #(
  parameter int DEPTH = bfcs_pkg::MAX_EDGES_DEF,
  parameter int AW    = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire bfcs_pkg::edge_t   wdata,
  input  wire logic [AW-1:0]     raddr,
  output bfcs_pkg::edge_t        rdata
);

  bfcs_pkg::edge_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/bfcs_dist_row.sv @@
// Distance row memory: one write port and two registered read ports.
// Depends on bfcs_pkg.
`default_nettype none
module bfcs_dist_row #(
  parameter int DEPTH = bfcs_pkg::MAX_NODES_DEF,
  parameter int AW    = 6
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [bfcs_pkg::DIST_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr0,
  input  wire logic [AW-1:0]               raddr1,
  output logic      [bfcs_pkg::DIST_W-1:0] rdata0,
  output logic      [bfcs_pkg::DIST_W-1:0] rdata1
);

  logic [bfcs_pkg::DIST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
`default_nettype wire

@@ rtl/bellman_ford_threshold_city_select.sv @@
// Top level of the threshold city selector: configuration registers,
// run sequencer and counters. Depends on bfcs_pkg, bfcs_relax_unit,
// bfcs_edge_store and bfcs_dist_row.
//
//   channel   signals                                          handshake
//   item in   start, cmd, edge_start, edge_end, edge_weight    start & !busy
//   result    done, best_city, reachable_count, edges_dropped  done, one cycle
//   config    cfg_valid, cfg_index, cfg_data, cfg_ready        cfg_valid & cfg_ready
//
// An edge load leaves busy low, so loads may follow back to back. A run walks the n
// sources in turn: it writes the distance row, relaxes the E stored edges over
// n - 1 rounds, then counts and picks. Each edge passes through an edge read, a
// distance read and two relaxation steps (node_b, then node_a) in the shared
// relaxation unit; an edge with an endpoint at or above n skips those two steps.
// Reset is synchronous; it clears the edge count, the overflow flag and the threshold
// and sets the node count to 64. The receiver cannot stall; done marks each result.
`default_nettype none
module bellman_ford_threshold_city_select #(
  parameter int MAX_NODES = bfcs_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = bfcs_pkg::MAX_EDGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           cmd,
  input  wire logic [bfcs_pkg::NODE_ID_W-1:0] edge_start,
  input  wire logic [bfcs_pkg::NODE_ID_W-1:0] edge_end,
  input  wire logic [bfcs_pkg::WEIGHT_W-1:0]  edge_weight,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bfcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bfcs_pkg::THR_W-1:0]     cfg_data,
  output logic                                done,
  output logic      [bfcs_pkg::NODE_ID_W-1:0] best_city,
  output logic      [bfcs_pkg::NODE_ID_W-1:0] reachable_count,
  output logic                                edges_dropped
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_W   = $clog2(MAX_EDGES + 1);

  bfcs_pkg::state_t state, state_next;

  logic [bfcs_pkg::NCOUNT_W-1:0] node_count;
  logic [bfcs_pkg::THR_W-1:0]    distance_threshold;
  logic [ET_W-1:0]               edge_total;
  logic                          overflow_seen;

  logic [CNT_W-1:0] n_reg;
  logic [CNT_W-1:0] src;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] fewest;
  logic [CNT_W-1:0] best;
  logic [ET_W-1:0]  k;
  logic [bfcs_pkg::DIST_W-1:0] db_new;

  logic [CNT_W-1:0] n_clamped;
  logic             add_acc;
  logic             run_acc;
  logic             store_room;
  logic             last_edge;
  logic             last_round;
  logic             last_node;
  logic             last_src;
  logic             skip_edge;

  bfcs_pkg::edge_t edge_wr;
  bfcs_pkg::edge_t edge_rd;
  logic            edge_we;

  logic                        dist_we;
  logic [NODE_W-1:0]           dist_waddr;
  logic [bfcs_pkg::DIST_W-1:0] dist_wdata;
  logic [NODE_W-1:0]           dist_raddr0;
  logic [NODE_W-1:0]           dist_raddr1;
  logic [bfcs_pkg::DIST_W-1:0] q0;
  logic [bfcs_pkg::DIST_W-1:0] q1;

  logic [bfcs_pkg::DIST_W-1:0] ru_dist;
  logic [bfcs_pkg::DIST_W-1:0] ru_cur;
  bfcs_pkg::relax_t            relax;

  always_comb begin
    if (32'(node_count) > MAX_NODES) begin
      n_clamped = CNT_W'(MAX_NODES);
    end else if (node_count == '0) begin
      n_clamped = CNT_W'(1);
    end else begin
      n_clamped = CNT_W'(node_count);
    end
  end

  assign cfg_ready  = 1'b1;
  assign add_acc    = start && !busy && (cmd == bfcs_pkg::CMD_ADD_EDGE);
  assign run_acc    = start && !busy && (cmd == bfcs_pkg::CMD_RUN);
  assign store_room = (32'(edge_total) < MAX_EDGES);
  assign last_edge  = ((k + ET_W'(1)) == edge_total);
  assign last_round = ((r + CNT_W'(1)) == n_reg);
  assign last_node  = ((j + CNT_W'(1)) == n_reg);
  assign last_src   = ((src + CNT_W'(1)) == n_reg);
  assign skip_edge  = (32'(edge_rd.node_a) >= 32'(n_reg)) ||
                      (32'(edge_rd.node_b) >= 32'(n_reg));

  assign edge_wr.node_a = edge_start;
  assign edge_wr.node_b = edge_end;
  assign edge_wr.weight = edge_weight;
  assign edge_we        = add_acc && store_room;

  bfcs_edge_store #(
    .DEPTH(MAX_EDGES),
    .AW   (EA_W)
  ) u_edge_store (
    .clk  (clk),
    .we   (edge_we),
    .waddr(edge_total[EA_W-1:0]),
    .wdata(edge_wr),
    .raddr(k[EA_W-1:0]),
    .rdata(edge_rd)
  );

  bfcs_dist_row #(
    .DEPTH(MAX_NODES),
    .AW   (NODE_W)
  ) u_dist_row (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr0(dist_raddr0),
    .raddr1(dist_raddr1),
    .rdata0(q0),
    .rdata1(q1)
  );

  bfcs_relax_unit u_relax (
    .base_dist(ru_dist),
    .weight   (edge_rd.weight),
    .cur      (ru_cur),
    .result   (relax)
  );

  always_comb begin
    state_next = state;
    case (state)
      bfcs_pkg::ST_IDLE: begin
        if (run_acc) state_next = bfcs_pkg::ST_INIT;
      end
      bfcs_pkg::ST_INIT: begin
        if (last_node) begin
          if ((n_reg == CNT_W'(1)) || (edge_total == '0)) begin
            state_next = bfcs_pkg::ST_CNT_RD;
          end else begin
            state_next = bfcs_pkg::ST_EDGE_RD;
          end
        end
      end
      bfcs_pkg::ST_EDGE_RD: state_next = bfcs_pkg::ST_DIST_RD;
      bfcs_pkg::ST_DIST_RD: begin
        if (!skip_edge) begin
          state_next = bfcs_pkg::ST_RELAX_B;
        end else if (last_edge && last_round) begin
          state_next = bfcs_pkg::ST_CNT_RD;
        end else begin
          state_next = bfcs_pkg::ST_EDGE_RD;
        end
      end
      bfcs_pkg::ST_RELAX_B: state_next = bfcs_pkg::ST_RELAX_A;
      bfcs_pkg::ST_RELAX_A: begin
        if (last_edge && last_round) begin
          state_next = bfcs_pkg::ST_CNT_RD;
        end else begin
          state_next = bfcs_pkg::ST_EDGE_RD;
        end
      end
      bfcs_pkg::ST_CNT_RD: state_next = bfcs_pkg::ST_CNT_CHK;
      bfcs_pkg::ST_CNT_CHK: begin
        state_next = last_node ? bfcs_pkg::ST_PICK : bfcs_pkg::ST_CNT_RD;
      end
      bfcs_pkg::ST_PICK: begin
        state_next = last_src ? bfcs_pkg::ST_DONE : bfcs_pkg::ST_INIT;
      end
      bfcs_pkg::ST_DONE: state_next = bfcs_pkg::ST_IDLE;
      default: state_next = bfcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != bfcs_pkg::ST_IDLE);
    done        = (state == bfcs_pkg::ST_DONE);
    dist_we     = 1'b0;
    dist_waddr  = NODE_W'(edge_rd.node_b);
    dist_wdata  = relax.value;
    dist_raddr0 = NODE_W'(edge_rd.node_a);
    dist_raddr1 = NODE_W'(edge_rd.node_b);
    ru_dist     = q0;
    ru_cur      = q1;
    case (state)
      bfcs_pkg::ST_INIT: begin
        dist_we    = 1'b1;
        dist_waddr = j[NODE_W-1:0];
        dist_wdata = (j == src) ? bfcs_pkg::DIST_ZERO : bfcs_pkg::DIST_INF;
      end
      bfcs_pkg::ST_RELAX_B: begin
        dist_we = relax.lower;
      end
      bfcs_pkg::ST_RELAX_A: begin
        ru_dist    = db_new;
        ru_cur     = q0;
        dist_we    = relax.lower;
        dist_waddr = NODE_W'(edge_rd.node_a);
      end
      bfcs_pkg::ST_CNT_RD: begin
        dist_raddr0 = j[NODE_W-1:0];
      end
      default: begin
        dist_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= bfcs_pkg::ST_IDLE;
      node_count         <= bfcs_pkg::NODE_COUNT_RST;
      distance_threshold <= '0;
      edge_total         <= '0;
      overflow_seen      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bfcs_pkg::CFG_NODE_COUNT: node_count <= cfg_data[bfcs_pkg::NCOUNT_W-1:0];
          bfcs_pkg::CFG_THRESHOLD:  distance_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (add_acc) begin
        if (store_room) begin
          edge_total <= edge_total + ET_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (state == bfcs_pkg::ST_DONE) begin
        edge_total    <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bfcs_pkg::ST_IDLE: begin
        if (run_acc) begin
          n_reg  <= n_clamped;
          fewest <= n_clamped;
          src    <= '0;
          best   <= '0;
          j      <= '0;
        end
      end
      bfcs_pkg::ST_INIT: begin
        if (last_node) begin
          j   <= '0;
          k   <= '0;
          r   <= CNT_W'(1);
          cnt <= '0;
        end else begin
          j <= j + CNT_W'(1);
        end
      end
      bfcs_pkg::ST_DIST_RD: begin
        if (skip_edge) begin
          if (last_edge) begin
            k <= '0;
            r <= r + CNT_W'(1);
          end else begin
            k <= k + ET_W'(1);
          end
        end
      end
      bfcs_pkg::ST_RELAX_B: begin
        db_new <= relax.lower ? relax.value : q1;
      end
      bfcs_pkg::ST_RELAX_A: begin
        if (last_edge) begin
          k <= '0;
          r <= r + CNT_W'(1);
        end else begin
          k <= k + ET_W'(1);
        end
      end
      bfcs_pkg::ST_CNT_CHK: begin
        if ((j != src) && (q0 <= {1'b0, distance_threshold})) begin
          cnt <= cnt + CNT_W'(1);
        end
        j <= j + CNT_W'(1);
      end
      bfcs_pkg::ST_PICK: begin
        if (cnt <= fewest) begin
          fewest <= cnt;
          best   <= src;
        end
        src <= src + CNT_W'(1);
        j   <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_city       <= '0;
      reachable_count <= '0;
      edges_dropped   <= 1'b0;
    end else if (state_next == bfcs_pkg::ST_DONE) begin
      if (cnt <= fewest) begin
        best_city       <= bfcs_pkg::NODE_ID_W'(src);
        reachable_count <= bfcs_pkg::NODE_ID_W'(cnt);
      end else begin
        best_city       <= bfcs_pkg::NODE_ID_W'(best);
        reachable_count <= bfcs_pkg::NODE_ID_W'(fewest);
      end
      edges_dropped <= overflow_seen;
    end
  end

  // The result strobe lasts one cycle and the block is idle right after it.
  assert property (@(posedge clk) disable iff (rst) done |=> !busy && !done)
    else $error("result strobe not followed by idle");

  assert property (@(posedge clk) disable iff (rst) 32'(edge_total) <= MAX_EDGES)
    else $error("edge count beyond store depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == bfcs_pkg::ST_RELAX_B || state == bfcs_pkg::ST_RELAX_A) |-> (k < edge_total))
    else $error("relaxation walk past the stored edges");

  assert property (@(posedge clk) disable iff (rst)
    (state == bfcs_pkg::ST_INIT || state == bfcs_pkg::ST_PICK) |-> (src < n_reg))
    else $error("source index out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == bfcs_pkg::ST_INIT) |-> (j < n_reg))
    else $error("node index out of range");

  assert property (@(posedge clk) disable iff (rst) run_acc |=> busy)
    else $error("run item accepted without going busy");

endmodule
`default_nettype wire

@@ dv/bellman_ford_threshold_city_select_test.sv @@
// Testbench for bellman_ford_threshold_city_select: random and directed edge loads and runs,
// with a built-in shortest path predictor that checks every reported city.
// Depends on bfcs_pkg and the top level of the block.
`default_nettype none
module bellman_ford_threshold_city_select_test;
  import bfcs_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 600000;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_ITEMS    = 75;
  localparam int OVERFLOW_PHASE = 5;
  localparam int WIDE_PHASE     = 11;

  localparam int unsigned IDLE_MIX [3] = '{0, 63, 7};

  typedef struct packed {
    logic                 cmd;
    logic [NODE_ID_W-1:0] node_a;
    logic [NODE_ID_W-1:0] node_b;
    logic [WEIGHT_W-1:0]  weight;
  } request_t;

  typedef struct packed {
    logic [NODE_ID_W-1:0] city;
    logic [NODE_ID_W-1:0] reach;
    logic                 dropped;
  } city_report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 cmd = 1'b0;
  logic [NODE_ID_W-1:0] edge_start = '0;
  logic [NODE_ID_W-1:0] edge_end = '0;
  logic [WEIGHT_W-1:0]  edge_weight = '0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NODE_COUNT;
  logic [THR_W-1:0]     cfg_data = '0;
  logic                 done;
  logic [NODE_ID_W-1:0] best_city;
  logic [NODE_ID_W-1:0] reachable_count;
  logic                 edges_dropped;

  request_t     item_backlog [$];
  city_report_t city_reports [$];
  int unsigned  idle_pct = 0;
  logic         item_taken = 1'b0;
  int unsigned  quiet_cycles = 0;
  int unsigned  mismatches = 0;

  edge_t             road_store [MAX_EDGES_DEF];
  int unsigned       road_total = 0;
  logic              road_overflow = 1'b0;
  logic [NCOUNT_W-1:0] model_nodes = NODE_COUNT_RST;
  logic [THR_W-1:0]  model_threshold = '0;

  bellman_ford_threshold_city_select i_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .edge_start      (edge_start),
    .edge_end        (edge_end),
    .edge_weight     (edge_weight),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .best_city       (best_city),
    .reachable_count (reachable_count),
    .edges_dropped   (edges_dropped)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic logic [DIST_W-1:0] extend_path(input logic [DIST_W-1:0] path_len,
                                                    input logic [WEIGHT_W-1:0] w);
    logic [DIST_W:0] sum;
    if (path_len >= DIST_INF) return DIST_INF;
    sum = {1'b0, path_len} + (DIST_W + 1)'(w);
    return (sum >= (DIST_W + 1)'(DIST_INF)) ? DIST_INF : sum[DIST_W-1:0];
  endfunction

  function automatic city_report_t pick_quietest_city();
    logic [DIST_W-1:0] dist_row [MAX_NODES_DEF];
    logic [DIST_W-1:0] cand;
    int unsigned n, src, round, k, j, tally, fewest, best;
    edge_t road;
    city_report_t rep;
    n = (model_nodes > NCOUNT_W'(MAX_NODES_DEF)) ? MAX_NODES_DEF : int'(model_nodes);
    if (n == 0) n = 1;
    fewest = n;
    best = 0;
    for (src = 0; src < n; src++) begin
      for (j = 0; j < n; j++) dist_row[j] = DIST_INF;
      dist_row[src] = DIST_ZERO;
      for (round = 1; round < n; round++) begin
        for (k = 0; k < road_total; k++) begin
          road = road_store[k];
          if (road.node_a < n && road.node_b < n) begin
            cand = extend_path(dist_row[road.node_a], road.weight);
            if (cand < dist_row[road.node_b]) dist_row[road.node_b] = cand;
            cand = extend_path(dist_row[road.node_b], road.weight);
            if (cand < dist_row[road.node_a]) dist_row[road.node_a] = cand;
          end
        end
      end
      tally = 0;
      for (j = 0; j < n; j++) begin
        if (j != src && dist_row[j] <= {1'b0, model_threshold}) tally++;
      end
      if (tally <= fewest) begin
        fewest = tally;
        best = src;
      end
    end
    rep.city = NODE_ID_W'(best);
    rep.reach = NODE_ID_W'(fewest);
    rep.dropped = road_overflow;
    return rep;
  endfunction

  function automatic logic [NODE_ID_W-1:0] pick_node(input int unsigned nodes);
    return NODE_ID_W'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(nodes - 1));
  endfunction

  task automatic add_road(input logic [NODE_ID_W-1:0] a, input logic [NODE_ID_W-1:0] b,
                          input logic [WEIGHT_W-1:0] w);
    item_backlog.push_back('{cmd: CMD_ADD_EDGE, node_a: a, node_b: b, weight: w});
  endtask

  task automatic add_run();
    item_backlog.push_back('{cmd: CMD_RUN, node_a: NODE_ID_W'($urandom),
                             node_b: NODE_ID_W'($urandom), weight: WEIGHT_W'($urandom)});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (item_backlog.size() != 0 || start || city_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: a held item stays on the ports until the block takes it.
  always @(negedge clk) begin
    request_t req;
    if (!start || item_taken) begin
      if (item_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req = item_backlog.pop_front();
        start <= 1'b1;
        cmd <= req.cmd;
        edge_start <= req.node_a;
        edge_end <= req.node_b;
        edge_weight <= req.weight;
      end else begin
        start <= 1'b0;
        cmd <= 1'($urandom_range(1));
        edge_start <= NODE_ID_W'($urandom);
        edge_end <= NODE_ID_W'($urandom);
        edge_weight <= WEIGHT_W'($urandom);
      end
    end
  end

  // Monitor: tracks configuration, predicts each run and checks each report.
  always @(posedge clk) begin
    city_report_t want;
    if (rst) begin
      item_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      item_taken <= start && !busy;
      quiet_cycles <= ((start && !busy) || (cfg_valid && cfg_ready) || done) ?
                      0 : quiet_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NODE_COUNT) model_nodes = cfg_data[NCOUNT_W-1:0];
        else model_threshold = cfg_data;
      end
      if (start && !busy) begin
        if (cmd == CMD_ADD_EDGE) begin
          if (road_total < MAX_EDGES_DEF) begin
            road_store[road_total] = '{node_a: edge_start, node_b: edge_end,
                                       weight: edge_weight};
            road_total++;
          end else begin
            road_overflow = 1'b1;
          end
        end else begin
          city_reports.push_back(pick_quietest_city());
          road_total = 0;
          road_overflow = 1'b0;
        end
      end
      if (done) begin
        if (city_reports.size() == 0) begin
          $display("%0t: no report expected, actual best_city %0d reachable_count %0d %s %0d",
                   $time, best_city, reachable_count, "edges_dropped", edges_dropped);
          mismatches++;
        end else begin
          want = city_reports.pop_front();
          if (best_city !== want.city) begin
            $display("%0t: best_city expected %0d, actual %0d", $time, want.city, best_city);
            mismatches++;
          end
          if (reachable_count !== want.reach) begin
            $display("%0t: reachable_count expected %0d, actual %0d",
                     $time, want.reach, reachable_count);
            mismatches++;
          end
          if (edges_dropped !== want.dropped) begin
            $display("%0t: edges_dropped expected %0d, actual %0d",
                     $time, want.dropped, edges_dropped);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bellman_ford_threshold_city_select_test failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase, nodes, wmax, tally, roads;
    logic [THR_W-1:0] thresh;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration with an empty store: every city reaches nobody.
    add_run();
    settle();

    // Small graph with zero and full weights, a self loop and out-of-range endpoints.
    write_reg(CFG_NODE_COUNT, 22'd5);
    write_reg(CFG_THRESHOLD, 22'd10);
    add_road(6'd0, 6'd1, 16'd3);
    add_road(6'd1, 6'd2, 16'd4);
    add_road(6'd2, 6'd3, 16'd0);
    add_road(6'd3, 6'd4, 16'hFFFF);
    add_road(6'd4, 6'd4, 16'd7);
    add_road(6'd63, 6'd1, 16'd1);
    add_road(6'd2, 6'd63, 16'd9);
    add_road(6'd0, 6'd0, 16'd0);
    add_run();
    settle();

    // A node count of zero acts as a single node; upper data bits are ignored.
    write_reg(CFG_NODE_COUNT, 22'h3FFF80);
    add_road(6'd0, 6'd1, 16'd5);
    add_run();
    settle();

    // Node count above the maximum is clamped; the largest threshold counts every path.
    write_reg(CFG_NODE_COUNT, 22'd127);
    write_reg(CFG_THRESHOLD, {THR_W{1'b1}});
    add_road(6'd0, 6'd63, 16'hFFFF);
    add_road(6'd10, 6'd20, 16'd1);
    add_run();
    settle();

    write_reg(CFG_NODE_COUNT, 22'd1);
    add_road(6'd0, 6'd0, 16'd1);
    add_run();
    settle();

    // Two nodes tied on count: the higher index wins.
    write_reg(CFG_NODE_COUNT, 22'd2);
    write_reg(CFG_THRESHOLD, 22'd0);
    add_road(6'd0, 6'd1, 16'd0);
    add_road(6'd1, 6'd0, 16'd0);
    add_run();
    settle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_pct = IDLE_MIX[phase % 3];
      if (phase == OVERFLOW_PHASE) begin
        // Fill the store past capacity, then check that a second run sees it cleared.
        write_reg(CFG_NODE_COUNT, {15'($urandom_range(32767)), 7'd2});
        write_reg(CFG_THRESHOLD, 22'($urandom_range(3)));
        repeat (MAX_EDGES_DEF + 1 + $urandom_range(3))
          add_road(NODE_ID_W'($urandom_range(1)), NODE_ID_W'($urandom_range(1)),
                   WEIGHT_W'($urandom_range(3)));
        add_run();
        add_run();
      end else if (phase == WIDE_PHASE) begin
        write_reg(CFG_NODE_COUNT, {15'($urandom_range(32767)), 7'd64});
        write_reg(CFG_THRESHOLD, 22'($urandom_range(200000)));
        repeat (6) add_road(NODE_ID_W'($urandom_range(63)), NODE_ID_W'($urandom_range(63)),
                            WEIGHT_W'($urandom));
        add_run();
      end else begin
        nodes = $urandom_range(2, 12);
        case ($urandom_range(2))
          0: wmax = 15;
          1: wmax = 1023;
          default: wmax = 65535;
        endcase
        case ($urandom_range(3))
          0: thresh = '0;
          1: thresh = {THR_W{1'b1}};
          default: thresh = THR_W'($urandom_range(wmax * 3));
        endcase
        write_reg(CFG_NODE_COUNT, {15'($urandom_range(32767)), 7'(nodes)});
        write_reg(CFG_THRESHOLD, thresh);
        tally = 0;
        while (tally < PHASE_ITEMS) begin
          roads = $urandom_range(3 * nodes);
          repeat (roads) add_road(pick_node(nodes), pick_node(nodes),
                                  WEIGHT_W'($urandom_range(wmax)));
          add_run();
          tally += roads + 1;
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("bellman_ford_threshold_city_select_test passed");
    end else begin
      $display("bellman_ford_threshold_city_select_test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
